/* rtl/core/picc_pkg.sv */
// Shared types, constants and arithmetic helpers for the clamped PI controller.
`default_nettype none
package picc_pkg;

	localparam int DATA_BITS      = 16;
	localparam int GAIN_FRAC_BITS = 12;

	localparam int ERR_W  = DATA_BITS + 1;
	localparam int PROD_W = DATA_BITS + ERR_W;
	localparam int ACC_W  = DATA_BITS + GAIN_FRAC_BITS;
	localparam int SAT_W  = DATA_BITS + GAIN_FRAC_BITS + 3;
	localparam int WIDE_W = ((PROD_W > SAT_W) ? PROD_W : SAT_W) + 1;
	localparam int SUM_W  = SAT_W + 1;

	localparam int REG_COUNT = 6;
	localparam int REG_IDX_W = $clog2(REG_COUNT);
	localparam int ADDR_W    = REG_IDX_W + 2;
	localparam int APB_W     = (DATA_BITS > 32) ? 64 : 32;

	localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_INTEG_LOW  = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_INTEG_HIGH = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_OUT_LOW    = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_OUT_HIGH   = REG_IDX_W'(5);

	localparam logic signed [DATA_BITS-1:0] LIMIT_RST_HI = {1'b0, {(DATA_BITS-1){1'b1}}};
	localparam logic signed [DATA_BITS-1:0] LIMIT_RST_LO =
		{1'b1, {(DATA_BITS-2){1'b0}}, 1'b1};

	// product saturation bound, +-2^(DATA_BITS+GAIN_FRAC_BITS+1)
	localparam logic signed [WIDE_W-1:0] PROD_LIM =
		WIDE_W'(1) <<< (DATA_BITS + GAIN_FRAC_BITS + 1);

	typedef enum logic [1:0] {
		CMD_RUN   = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2
	} picc_cmd_t;

	typedef struct packed {
		logic [1:0]                  cmd;
		logic signed [DATA_BITS-1:0] setpoint;
		logic signed [DATA_BITS-1:0] measured;
		logic signed [DATA_BITS-1:0] hold_value;
	} picc_req_t;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] drive;
		logic                        running;
	} picc_res_t;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] prop_gain;
		logic signed [DATA_BITS-1:0] integ_gain;
		logic signed [DATA_BITS-1:0] integ_low;
		logic signed [DATA_BITS-1:0] integ_high;
		logic signed [DATA_BITS-1:0] out_low;
		logic signed [DATA_BITS-1:0] out_high;
	} picc_cfg_t;

	typedef struct packed {
		logic signed [ACC_W-1:0]     integ_acc;
		logic signed [DATA_BITS-1:0] drive;
		logic                        running;
	} picc_state_t;

	function automatic logic signed [SAT_W-1:0] sat_prod(input logic signed [PROD_W-1:0] p);
		logic signed [WIDE_W-1:0] w;
		logic signed [WIDE_W-1:0] r;
		w = WIDE_W'(p);
		r = w;
		if (w < -PROD_LIM) begin
			r = -PROD_LIM;
		end
		if (w > PROD_LIM) begin
			r = PROD_LIM;
		end
		return SAT_W'(r);
	endfunction

	// lower bound first, upper bound last: a crossed pair resolves to the upper
	function automatic logic signed [SUM_W-1:0] clamp_sum(input logic signed [SUM_W-1:0] v,
		input logic signed [SUM_W-1:0] lo, input logic signed [SUM_W-1:0] hi);
		logic signed [SUM_W-1:0] r;
		r = v;
		if (r < lo) begin
			r = lo;
		end
		if (r > hi) begin
			r = hi;
		end
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] scale_limit(
		input logic signed [DATA_BITS-1:0] x);
		logic signed [ACC_W-1:0] s;
		s = $signed({x, {GAIN_FRAC_BITS{1'b0}}});
		return SUM_W'(s);
	endfunction

endpackage
`default_nettype wire

/* rtl/core/picc_apb_regs.sv */
// APB-style register file holding gains and clamp limits.
`default_nettype none
module picc_apb_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [picc_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [picc_pkg::APB_W-1:0]    pwdata,
	output logic      [picc_pkg::APB_W-1:0]    prdata,
	output logic                               pready,
	output picc_pkg::picc_cfg_t                cfg
);
	import picc_pkg::*;

	picc_cfg_t               cfg_q;
	logic [REG_IDX_W-1:0]    idx;
	logic                    wr_en;
	logic [DATA_BITS-1:0]    wval;
	logic signed [DATA_BITS-1:0] rval;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign wval   = pwdata[DATA_BITS-1:0];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain  <= '0;
			cfg_q.integ_gain <= '0;
			cfg_q.integ_low  <= LIMIT_RST_LO;
			cfg_q.integ_high <= LIMIT_RST_HI;
			cfg_q.out_low    <= LIMIT_RST_LO;
			cfg_q.out_high   <= LIMIT_RST_HI;
		end else if (wr_en) begin
			case (idx)
				REG_PROP_GAIN:  cfg_q.prop_gain  <= wval;
				REG_INTEG_GAIN: cfg_q.integ_gain <= wval;
				REG_INTEG_LOW:  cfg_q.integ_low  <= wval;
				REG_INTEG_HIGH: cfg_q.integ_high <= wval;
				REG_OUT_LOW:    cfg_q.out_low    <= wval;
				REG_OUT_HIGH:   cfg_q.out_high   <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PROP_GAIN:  rval = cfg_q.prop_gain;
			REG_INTEG_GAIN: rval = cfg_q.integ_gain;
			REG_INTEG_LOW:  rval = cfg_q.integ_low;
			REG_INTEG_HIGH: rval = cfg_q.integ_high;
			REG_OUT_LOW:    rval = cfg_q.out_low;
			REG_OUT_HIGH:   rval = cfg_q.out_high;
			default:        rval = '0;
		endcase
	end

	assign prdata = APB_W'(rval);

endmodule
`default_nettype wire

/* rtl/core/picc_step.sv */
// Loop step: error, integral update with clamp, output clamp and rounding, state registers.
`default_nettype none
module picc_step (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 fire,
	input  wire picc_pkg::picc_req_t  req,
	input  wire picc_pkg::picc_cfg_t  cfg,
	output picc_pkg::picc_state_t     state
);
	import picc_pkg::*;

	logic signed [ACC_W-1:0]     integ_q;
	logic signed [DATA_BITS-1:0] drive_q;
	logic                        loop_on_q;

	logic signed [ERR_W-1:0]     err;
	logic signed [PROD_W-1:0]    p_int;
	logic signed [PROD_W-1:0]    p_prop;
	logic signed [SUM_W-1:0]     acc_sum;
	logic signed [SUM_W-1:0]     acc_clamped;
	logic signed [SUM_W-1:0]     out_sum;
	logic signed [SUM_W-1:0]     out_clamped;
	logic signed [SUM_W-1:0]     out_rounded;

	logic signed [ACC_W-1:0]     integ_d;
	logic signed [DATA_BITS-1:0] drive_d;
	logic                        loop_on_d;

	assign err    = ERR_W'(req.setpoint) - ERR_W'(req.measured);
	assign p_int  = PROD_W'(cfg.integ_gain) * PROD_W'(err);
	assign p_prop = PROD_W'(cfg.prop_gain) * PROD_W'(err);

	assign acc_sum     = SUM_W'(integ_q) + SUM_W'(sat_prod(p_int));
	assign acc_clamped = clamp_sum(acc_sum, scale_limit(cfg.integ_low),
		scale_limit(cfg.integ_high));
	assign out_sum     = SUM_W'(sat_prod(p_prop)) + acc_clamped;
	assign out_clamped = clamp_sum(out_sum, scale_limit(cfg.out_low),
		scale_limit(cfg.out_high));
	// round half up
	assign out_rounded = (out_clamped + (SUM_W'(1) <<< (GAIN_FRAC_BITS - 1)))
		>>> GAIN_FRAC_BITS;

	always_comb begin
		integ_d   = integ_q;
		drive_d   = drive_q;
		loop_on_d = loop_on_q;
		case (req.cmd)
			CMD_RUN: begin
				if (loop_on_q) begin
					integ_d = ACC_W'(acc_clamped);
					drive_d = DATA_BITS'(out_rounded);
				end
			end
			CMD_START: begin
				loop_on_d = 1'b1;
			end
			CMD_STOP: begin
				integ_d   = '0;
				drive_d   = req.hold_value;
				loop_on_d = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q   <= '0;
			drive_q   <= '0;
			loop_on_q <= 1'b0;
		end else if (fire) begin
			integ_q   <= integ_d;
			drive_q   <= drive_d;
			loop_on_q <= loop_on_d;
		end
	end

	assign state.integ_acc = integ_q;
	assign state.drive     = drive_q;
	assign state.running   = loop_on_q;

endmodule
`default_nettype wire

/* rtl/core/pi_controller_clamped_core.sv */
// Top level of the clamped PI controller: request register, loop step and result handshake.
// Fixed-point PI regulator (signed Q15.0 samples, Q3.12 gains, integral with 12 fraction
// bits) with integral anti-windup and output clamps. Each request gives exactly one result,
// the output after that request and the run flag. A request is registered on acceptance and
// its result is registered when the request stage advances, so a new request is taken every
// cycle unless results stall. The rate is set by the integral recurrence: error, two 16x17
// multiplies, the integral add and clamp, and the output add, clamp and round all sit
// between the request register and the state/result registers. Configuration goes through
// the APB-style port and should only change while no request is in flight.
`default_nettype none
module pi_controller_clamped_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire picc_pkg::picc_req_t           req_data,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output picc_pkg::picc_res_t                res_data,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [picc_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [picc_pkg::APB_W-1:0]    pwdata,
	output logic      [picc_pkg::APB_W-1:0]    prdata,
	output logic                               pready
);
	import picc_pkg::*;

	picc_cfg_t   cfg;
	picc_state_t state;
	picc_req_t   req_s1;
	logic        valid_s1;
	logic        res_valid_q;
	logic        advance;
	logic        fire;

	assign advance   = !res_valid_q || !res_stall;
	assign fire      = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req_data;
		end
	end

	picc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	picc_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.cfg    (cfg),
		.state  (state)
	);

	assign res_valid        = res_valid_q;
	assign res_data.drive   = state.drive;
	assign res_data.running = state.running;

	a_stopped_integ_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!state.running |-> state.integ_acc == '0)
		else $error("integral not cleared while stopped");

	a_stop_loads_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_s1.cmd == CMD_STOP |=>
		!state.running && state.drive == $past(req_s1.hold_value))
		else $error("stop did not load hold value");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && res_valid_q && res_stall)
		else $error("request stalled with free stage");

endmodule
`default_nettype wire
